[hw/rtl/tplw_pkg.sv]
`default_nettype none
package tplw_pkg;
   localparam int MaxVertices  = 4096;
   localparam int MaxTriangles = 8192;
   localparam int CoordBits    = 20;
   localparam int InCoordW     = 20;

   localparam logic [1:0] ReqVertex   = 2'd0;
   localparam logic [1:0] ReqTriangle = 2'd1;
   localparam logic [1:0] ReqLocate   = 2'd2;

   localparam logic [1:0] StFound = 2'd0;
   localparam logic [1:0] StOff   = 2'd1;
   localparam logic [1:0] StLimit = 2'd2;

   localparam logic CsrTriCount  = 1'b0;
   localparam logic CsrStepLimit = 1'b1;

   // triangle record as kept in the mesh memory
   typedef struct packed {
      logic signed [13:0] nb2;
      logic signed [13:0] nb1;
      logic signed [13:0] nb0;
      logic [11:0] c2;
      logic [11:0] c1;
      logic [11:0] c0;
   } tri_rec_type;
endpackage
`default_nettype wire

[hw/rtl/triangle_point_location_walk.sv]
`default_nettype none
// Lawson-walk point locator over a mesh held in on-chip memories. Load words
// (vertex, triangle) are taken only while the locator is idle. A locate word walks
// from the last triangle in use; each edge test steps through two vertex reads
// that share the vertex memory port (S_V1, S_V2), two product states (S_P1,
// S_P2) and a decision state (S_DEC), and each triangle entered adds a record
// read (S_TRD); an empty mesh goes straight to its result without a walk. The
// single vertex memory read port sets the pace of each edge test. One query at
// a time; the result sits in an output register while the next word may be
// taken, and a finished walk waits only while that register still holds an
// unaccepted result.
module triangle_point_location_walk
   import tplw_pkg::*;
#(
   parameter int MAX_VERTICES  = MaxVertices,
   parameter int MAX_TRIANGLES = MaxTriangles,
   parameter int COORD_BITS    = CoordBits
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // tdata: entry_index[12:0], coord_x[32:13], coord_y[52:33], corner0[64:53],
   // corner1[76:65], corner2[88:77], neighbor0[102:89], neighbor1[116:103],
   // neighbor2[130:117], zero fill to 136
   input  wire logic [135:0] req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata: triangle_id[13:0], status[15:14], moves_taken[31:16]
   output logic [31:0] rsp_tdata,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int TW = $clog2(MAX_TRIANGLES);
   localparam int KW = (COORD_BITS < InCoordW) ? COORD_BITS : InCoordW;

   localparam logic [2:0] S_IDLE = 3'd0, S_TRD = 3'd1, S_V1 = 3'd2, S_V2 = 3'd3,
                          S_P1 = 3'd4, S_P2 = 3'd5, S_DEC = 3'd6, S_OUT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [13:0] tcount_ff;
   logic [15:0] limit_ff;
   logic [14:0] tc_eff;

   // memories
   logic signed [KW-1:0] vx_mem [MAX_VERTICES];
   logic signed [KW-1:0] vy_mem [MAX_VERTICES];
   tri_rec_type tri_mem [MAX_TRIANGLES];
   logic signed [KW-1:0] vx_rd_ff, vy_rd_ff;
   tri_rec_type tri_rd_ff, rec_ff;
   logic v_oor_ff;

   logic [12:0] idx;
   logic signed [19:0] in_x, in_y;
   logic [1:0] rtype;
   logic req_fire, rsp_full_ff;

   logic signed [KW-1:0] px_ff, py_ff, x1_ff, y1_ff;
   logic [TW-1:0] tri_ff;
   logic [TW-1:0] tri_addr;
   logic [1:0] edge_ff;
   logic [15:0] moves_ff;
   logic [13:0] res_id_ff;
   logic [1:0] res_st_ff;
   logic [15:0] res_mv_ff;
   logic [31:0] rsp_data_ff;
   logic rsp_load;
   logic walk_off, at_limit;
   logic [11:0] vaddr;
   logic pos;
   logic [11:0] cur_c, nxt_c;
   logic signed [13:0] cur_nb;
   logic signed [KW:0] ox1, oy1, ox2, oy2;

   assign rtype = req_tuser;
   assign idx   = req_tdata[12:0];
   assign in_x  = req_tdata[32:13];
   assign in_y  = req_tdata[52:33];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign tc_eff = ({1'b0, tcount_ff} > 15'(MAX_TRIANGLES)) ? 15'(MAX_TRIANGLES)
                                                            : {1'b0, tcount_ff};

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tcount_ff <= '0;
         limit_ff  <= 16'd8192;
      end else if (csr_valid) begin
         if (csr_index == CsrTriCount) tcount_ff <= csr_data[13:0];
         else limit_ff <= csr_data;
      end
   end

   // load writes
   always_ff @(posedge clock) begin
      if (req_fire && rtype == ReqVertex && {3'b0, idx} < 16'(MAX_VERTICES)) begin
         vx_mem[idx[VW-1:0]] <= in_x[KW-1:0];
         vy_mem[idx[VW-1:0]] <= in_y[KW-1:0];
      end
      if (req_fire && rtype == ReqTriangle && {3'b0, idx} < 16'(MAX_TRIANGLES))
         tri_mem[idx[TW-1:0]] <= req_tdata[130:53];
   end

   // edge corners from the held record
   always_comb begin
      unique case (edge_ff)
         2'd0: begin cur_c = rec_ff.c0; nxt_c = rec_ff.c1; cur_nb = rec_ff.nb0; end
         2'd1: begin cur_c = rec_ff.c1; nxt_c = rec_ff.c2; cur_nb = rec_ff.nb1; end
         default: begin cur_c = rec_ff.c2; nxt_c = rec_ff.c0; cur_nb = rec_ff.nb2; end
      endcase
   end
   assign vaddr = (state_ff == S_V1) ? cur_c : nxt_c;

   // record address: the triangle the walk enters next, so S_TRD sees fresh data
   always_comb begin
      if (state_ff == S_IDLE) tri_addr = TW'(tc_eff - 15'd1);
      else if (state_ff == S_DEC) tri_addr = cur_nb[TW-1:0];
      else tri_addr = tri_ff;
   end

   // memory reads
   always_ff @(posedge clock) begin
      tri_rd_ff <= tri_mem[tri_addr];
      vx_rd_ff  <= vx_mem[vaddr[VW-1:0]];
      vy_rd_ff  <= vy_mem[vaddr[VW-1:0]];
      v_oor_ff  <= {5'b0, vaddr} >= 17'(MAX_VERTICES);
   end

   assign ox1 = {x1_ff[KW-1], x1_ff} - {px_ff[KW-1], px_ff};
   assign oy1 = {y1_ff[KW-1], y1_ff} - {py_ff[KW-1], py_ff};
   assign ox2 = (v_oor_ff ? '0 : {vx_rd_ff[KW-1], vx_rd_ff}) - {px_ff[KW-1], px_ff};
   assign oy2 = (v_oor_ff ? '0 : {vy_rd_ff[KW-1], vy_rd_ff}) - {py_ff[KW-1], py_ff};

   tplw_orient #(.COORD_BITS(KW)) u_orient (
      .clock(clock), .a_in(oy1), .b_in(ox2), .c_in(ox1), .e_in(oy2), .pos_out(pos));

   // move checks at the decision cycle
   assign walk_off = (cur_nb < 0) || ({2'b00, cur_nb} >= {1'b0, tc_eff});
   assign at_limit = moves_ff >= limit_ff;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_full_ff || rsp_tready);

   // walk sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire && rtype == ReqLocate)
            state_in = (tc_eff == '0) ? S_OUT : S_TRD;
         S_TRD: state_in = S_V1;
         S_V1:  state_in = S_V2;
         S_V2:  state_in = S_P1;
         S_P1:  state_in = S_P2;
         S_P2:  state_in = S_DEC;
         S_DEC: begin
            if (pos && !walk_off && !at_limit) state_in = S_TRD;
            else if (!pos && edge_ff != 2'd2) state_in = S_V1;
            else state_in = S_OUT;
         end
         S_OUT: state_in = rsp_load ? S_IDLE : S_OUT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_full_ff <= 1'b1;
         else if (rsp_tvalid && rsp_tready) rsp_full_ff <= 1'b0;
         if (state_ff == S_DEC) begin
            if (pos) begin
               if (walk_off) begin
                  res_id_ff <= '1; res_st_ff <= StOff; res_mv_ff <= moves_ff;
               end else if (at_limit) begin
                  res_id_ff <= '1; res_st_ff <= StLimit; res_mv_ff <= moves_ff;
               end else begin
                  moves_ff <= moves_ff + 16'd1;
                  tri_ff   <= cur_nb[TW-1:0];
                  edge_ff  <= 2'd0;
               end
            end else if (edge_ff == 2'd2) begin
               res_id_ff <= 14'(tri_ff); res_st_ff <= StFound; res_mv_ff <= moves_ff;
            end else begin
               edge_ff  <= edge_ff + 2'd1;
            end
         end
      end
      if (state_ff == S_IDLE && req_fire && rtype == ReqLocate) begin
         px_ff <= in_x[KW-1:0];
         py_ff <= in_y[KW-1:0];
         moves_ff <= '0;
         edge_ff <= 2'd0;
         tri_ff <= TW'(tc_eff - 15'd1);
         res_id_ff <= '1; res_st_ff <= StOff; res_mv_ff <= '0;
      end
      if (state_ff == S_TRD) rec_ff <= tri_rd_ff;
      if (state_ff == S_V2) begin
         x1_ff <= v_oor_ff ? '0 : vx_rd_ff;
         y1_ff <= v_oor_ff ? '0 : vy_rd_ff;
      end
      if (rsp_load) rsp_data_ff <= {res_mv_ff, res_st_ff, res_id_ff};
   end

   assign rsp_tvalid = rsp_full_ff;
   assign rsp_tdata = rsp_data_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("accepted while walking");
   a_moves_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEC |-> moves_ff <= limit_ff || limit_ff == '0 || $past(reset))
      else $error("moves past limit");
   a_edge_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> edge_ff != 2'd3) else $error("bad edge");
endmodule
`default_nettype wire

[hw/rtl/tplw_orient.sv]
`default_nettype none
// Orientation product d = a*b - c*e; products registered, difference combinational.
module tplw_orient
   import tplw_pkg::*;
#(
   parameter int COORD_BITS = CoordBits
) (
   input  wire logic clock,
   input  wire logic signed [COORD_BITS:0] a_in,
   input  wire logic signed [COORD_BITS:0] b_in,
   input  wire logic signed [COORD_BITS:0] c_in,
   input  wire logic signed [COORD_BITS:0] e_in,
   output logic pos_out
);
   localparam int PW = 2 * COORD_BITS + 2;
   logic signed [PW-1:0] p0_ff, p1_ff;
   logic signed [PW:0] d_in;

   always_ff @(posedge clock) begin
      p0_ff <= a_in * b_in;
      p1_ff <= c_in * e_in;
   end

   assign d_in = {p0_ff[PW-1], p0_ff} - {p1_ff[PW-1], p1_ff};
   assign pos_out = !d_in[PW] && (d_in != '0);
endmodule
`default_nettype wire

[verif/triangle_point_location_walk_tb.sv]
`timescale 1ns / 1ps

module triangle_point_location_walk_tb;
   import tplw_pkg::*;

   localparam logic [1:0] ReqIdle = 2'd3;
   localparam int TargetWords = 1900;
   localparam int CycleLimit = 4000000;
   localparam int DrainCycles = 60;

   // input word as laid out on req_tdata, msb first
   typedef struct packed {
      logic [4:0] pad;
      logic signed [13:0] nb2;
      logic signed [13:0] nb1;
      logic signed [13:0] nb0;
      logic [11:0] c2;
      logic [11:0] c1;
      logic [11:0] c0;
      logic signed [19:0] y;
      logic signed [19:0] x;
      logic [12:0] idx;
   } req_word_t;

   // result word as laid out on rsp_tdata, msb first
   typedef struct packed {
      logic [15:0] moves;
      logic [1:0] status;
      logic signed [13:0] tri_id;
   } walk_result_t;

   // mesh mirror, walk predictor and queue of expected locate results
   class walk_scoreboard;
      logic signed [19:0] vx[MaxVertices];
      logic signed [19:0] vy[MaxVertices];
      tri_rec_type tris[MaxTriangles];
      int unsigned tri_count;
      int unsigned step_limit;
      walk_result_t located_q[$];

      function new();
         tri_count = 0;
         step_limit = 8192;
      endfunction

      function void set_reg(logic idx, logic [15:0] val);
         if (idx == CsrTriCount) tri_count = val & 16'h3FFF;
         else step_limit = val;
      endfunction

      function walk_result_t locate(logic signed [19:0] qx, logic signed [19:0] qy);
         walk_result_t r;
         tri_rec_type rec;
         longint px, py, x1, y1, x2, y2, d, t, nb, tc;
         logic [11:0] ca, cb;
         int e;
         int unsigned moves;
         logic [1:0] st;
         px = qx;
         py = qy;
         tc = (tri_count > MaxTriangles) ? MaxTriangles : tri_count;
         t = tc - 1;
         moves = 0;
         st = StFound;
         e = 0;
         if (t < 0) st = StOff;
         else begin
            while (e < 3) begin
               rec = tris[t];
               case (e)
                  0: begin ca = rec.c0; cb = rec.c1; nb = rec.nb0; end
                  1: begin ca = rec.c1; cb = rec.c2; nb = rec.nb1; end
                  default: begin ca = rec.c2; cb = rec.c0; nb = rec.nb2; end
               endcase
               x1 = vx[ca]; y1 = vy[ca]; x2 = vx[cb]; y2 = vy[cb];
               d = (y1 - py) * (x2 - px) - (x1 - px) * (y2 - py);
               if (d > 0) begin
                  if (nb < 0 || nb >= tc) begin
                     st = StOff; t = -1; break;
                  end
                  if (moves >= step_limit) begin
                     st = StLimit; t = -1; break;
                  end
                  moves++;
                  t = nb;
                  e = 0;
               end else e++;
            end
         end
         r.tri_id = t[13:0];
         r.status = st;
         r.moves = moves[15:0];
         return r;
      endfunction

      function void note_word(logic [1:0] kind, req_word_t w);
         if (kind == ReqVertex) begin
            if (w.idx < MaxVertices) begin
               vx[w.idx] = w.x;
               vy[w.idx] = w.y;
            end
         end else if (kind == ReqTriangle) begin
            tris[w.idx] = '{nb2: w.nb2, nb1: w.nb1, nb0: w.nb0, c2: w.c2, c1: w.c1, c0: w.c0};
         end else if (kind == ReqLocate) begin
            located_q = {located_q, locate(w.x, w.y)};
         end
      endfunction

      // returns 0 and a message on any mismatch
      function bit check_result(walk_result_t got, output string msg);
         walk_result_t exp_r;
         msg = "";
         if (located_q.size() == 0) begin
            $sformat(msg, "unexpected result %h", got);
            return 0;
         end
         exp_r = located_q.pop_front();
         if (got.tri_id !== exp_r.tri_id)
            msg = {msg, $sformatf(" triangle_id %0d/%0d", got.tri_id, exp_r.tri_id)};
         if (got.status !== exp_r.status)
            msg = {msg, $sformatf(" status %0d/%0d", got.status, exp_r.status)};
         if (got.moves !== exp_r.moves)
            msg = {msg, $sformatf(" moves_taken %0d/%0d", got.moves, exp_r.moves)};
         return msg == "";
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   walk_scoreboard board = new();
   int errors = 0;
   int words_sent = 0;
   int queries_sent = 0;
   int results_seen = 0;
   int phases = 0;
   int cycles = 0;
   int rsp_wait = 0;
   bit no_idle = 0;

   triangle_point_location_walk i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string msg);
      errors++;
      $display("[%0t] mismatch:%s", $time, msg);
   endtask

   // result side: random stalls, check on each accepted word
   always @(posedge clock) begin
      string msg;
      int next_wait;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         next_wait = rsp_wait;
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (!board.check_result(rsp_tdata, msg)) report(msg);
            next_wait = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (next_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait <= next_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_wait <= 0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("triangle_point_location_walk_tb NOT OK");
         $finish;
      end
   end

   // caller sits at a rising edge; valid stays up between back-to-back words
   task automatic send_word(input logic [1:0] kind, input req_word_t w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= 136'(w);
      req_tuser <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(kind, w);
      if (kind != ReqIdle) words_sent++;
      if (kind == ReqLocate) queries_sent++;
   endtask

   task automatic csr_write(input logic idx, input logic [15:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   // let every expected result arrive and the last load retire
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.located_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic req_word_t vtx_word(int idx, longint x, longint y);
      req_word_t w;
      w = req_word_t'(136'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      w.pad = '0;
      w.idx = 13'(idx);
      w.x = 20'(x);
      w.y = 20'(y);
      return w;
   endfunction

   function automatic req_word_t tri_word(int idx, int a, int b, int c, int n0, int n1, int n2);
      req_word_t w;
      w = vtx_word(idx, $urandom, $urandom);
      w.c0 = 12'(a); w.c1 = 12'(b); w.c2 = 12'(c);
      w.nb0 = 14'(n0); w.nb1 = 14'(n1); w.nb2 = 14'(n2);
      return w;
   endfunction

   function automatic longint clamp20(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   // extremes, empty mesh, count clamp, step limit 0 and 1, unused request
   task automatic directed_part();
      send_word(ReqLocate, vtx_word(0, 0, 0));
      send_word(ReqIdle, vtx_word($urandom, $urandom, $urandom));
      send_word(ReqVertex, vtx_word(0, -524288, -524288));
      send_word(ReqVertex, vtx_word(1, 524287, -524288));
      send_word(ReqVertex, vtx_word(2, -524288, 524287));
      send_word(ReqVertex, vtx_word(4095, 524287, 524287));
      send_word(ReqVertex, vtx_word(8191, 123, -456));
      send_word(ReqTriangle, tri_word(0, 0, 1, 2, -1, 8191, -1));
      send_word(ReqTriangle, tri_word(8191, 1, 4095, 2, -1, -1, 0));
      drain();
      csr_write(CsrTriCount, 16'd1);
      send_word(ReqLocate, vtx_word(0, -524288, -524288));
      send_word(ReqLocate, vtx_word(0, 524287, 524287));
      send_word(ReqLocate, vtx_word(0, 0, 0));
      send_word(ReqLocate, vtx_word(0, -1, -1));
      drain();
      csr_write(CsrTriCount, 16'hFFFF);
      csr_write(CsrStepLimit, 16'd0);
      send_word(ReqLocate, vtx_word(0, 524287, 524287));
      send_word(ReqLocate, vtx_word(0, -524288, -524288));
      drain();
      csr_write(CsrStepLimit, 16'd1);
      send_word(ReqLocate, vtx_word(0, -524288, -524288));
      send_word(ReqLocate, vtx_word(0, 0, -1));
      drain();
      csr_write(CsrTriCount, 16'd8192);
      csr_write(CsrStepLimit, 16'hFFFF);
      send_word(ReqLocate, vtx_word(0, -524288, 524287));
      send_word(ReqLocate, vtx_word(0, 524287, -524288));
      send_word(ReqLocate, vtx_word(0, 100, 100));
      drain();
   endtask

   // one random phase: grid mesh, registers, queries with noise mixed in
   task automatic random_phase();
      int nx, ny, nv, ntri, vbase, rot, sx, sy, ox, oy, tc, nq, i, j, k, sel, vi;
      int idx, a, b, n0, n1, n2;
      bit broken;
      longint qx, qy;
      nx = $urandom_range(1, 6);
      ny = $urandom_range(1, 6);
      nv = (nx + 1) * (ny + 1);
      ntri = 2 * nx * ny;
      vbase = $urandom_range(0, MaxVertices - nv);
      rot = $urandom_range(0, ntri - 1);
      sx = $urandom_range(1, 1048575 / (nx + 1));
      sy = $urandom_range(1, 1048575 / (ny + 1));
      ox = $urandom_range(0, 1048575 - nx * sx) - 524288;
      oy = $urandom_range(0, 1048575 - ny * sy) - 524288;
      broken = ($urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      phases++;

      // registers while idle
      sel = $urandom_range(0, 9);
      tc = (sel == 0) ? 0 : (sel < 3) ? $urandom_range(1, ntri) : ntri;
      csr_write(CsrTriCount, 16'(tc));
      if (broken) csr_write(CsrStepLimit, 16'($urandom_range(0, 40)));
      else begin
         sel = $urandom_range(0, 2);
         csr_write(CsrStepLimit, sel == 0 ? 16'hFFFF : sel == 1 ? 16'($urandom_range(1, 8))
                                                              : 16'($urandom_range(1, 65535)));
      end

      // vertices row by row, then the two triangles of each cell
      for (j = 0; j <= ny; j++)
         for (i = 0; i <= nx; i++)
            send_word(ReqVertex, vtx_word(vbase + j * (nx + 1) + i, ox + i * sx, oy + j * sy));
      for (j = 0; j < ny; j++)
         for (i = 0; i < nx; i++) begin
            a = (2 * (j * nx + i) + rot) % ntri;
            b = (2 * (j * nx + i) + 1 + rot) % ntri;
            vi = vbase + j * (nx + 1) + i;
            // lower-right: bottom, right, diagonal
            n0 = (j == 0) ? -1 : (2 * ((j - 1) * nx + i) + 1 + rot) % ntri;
            n1 = (i == nx - 1) ? -1 : (2 * (j * nx + i + 1) + 1 + rot) % ntri;
            send_word(ReqTriangle, tri_word(a, vi, vi + 1, vi + nx + 2, n0, n1, b));
            // upper-left: diagonal, top, left
            n1 = (j == ny - 1) ? -1 : (2 * ((j + 1) * nx + i) + rot) % ntri;
            n2 = (i == 0) ? -1 : (2 * (j * nx + i - 1) + rot) % ntri;
            send_word(ReqTriangle, tri_word(b, vi, vi + nx + 2, vi + nx + 1, a, n1, n2));
         end

      // broken meshes get records with scrambled links
      if (broken)
         for (k = $urandom_range(1, 3); k > 0; k--)
            send_word(ReqTriangle, tri_word($urandom_range(0, ntri - 1),
               vbase + $urandom_range(0, nv - 1), vbase + $urandom_range(0, nv - 1),
               vbase + $urandom_range(0, nv - 1), $urandom_range(0, ntri + 2) - 1,
               $urandom_range(0, ntri + 2) - 1, $urandom_range(0, ntri + 2) - 1));

      nq = $urandom_range(20, 60);
      for (k = 0; k < nq; k++) begin
         // noise on storage that no walk of this phase reads
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            idx = $urandom_range(0, 8191);
            if (idx >= vbase && idx < vbase + nv) idx += 4096;
            send_word(ReqVertex, vtx_word(idx, $urandom, $urandom));
         end else if (sel == 1) begin
            send_word(ReqTriangle, tri_word($urandom_range(ntri, 8191), $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom));
         end else if (sel == 2) begin
            send_word(ReqIdle, vtx_word($urandom, $urandom, $urandom));
         end
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            qx = ox + $urandom_range(0, nx) * sx;
            qy = oy + $urandom_range(0, ny) * sy;
         end else if (sel == 1) begin
            qx = $urandom_range(0, 1048575) - 524288;
            qy = $urandom_range(0, 1048575) - 524288;
         end else begin
            qx = clamp20(ox - sx / 4 + longint'($urandom_range(0, (nx * sx * 3) / 2)));
            qy = clamp20(oy - sy / 4 + longint'($urandom_range(0, (ny * sy * 3) / 2)));
         end
         send_word(ReqLocate, vtx_word($urandom, qx, qy));
      end
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_part();
      while (words_sent < TargetWords) random_phase();
      drain();
      $display("ran %0d load and locate words over %0d mesh phases", words_sent, phases);
      $display("checked %0d locate results, %0d mismatches", results_seen, errors);
      if (errors == 0 && board.located_q.size() == 0)
         $display("triangle_point_location_walk_tb OK");
      else
         $display("triangle_point_location_walk_tb NOT OK");
      $finish;
   end
endmodule

[sim.f]
hw/rtl/tplw_pkg.sv
hw/rtl/tplw_orient.sv
hw/rtl/triangle_point_location_walk.sv
verif/triangle_point_location_walk_tb.sv
